// ===== sv/tfo_pkg.sv =====
// Shared widths and cell payload types for the tangent frame orthonormalizer.
`timescale 1ns / 1ps

package tfo_pkg;

  // Component format: signed Q1.14
  localparam int CW = 16;
  localparam int FW = 14;
  // Magnitude of a saturated remainder component
  localparam int MW = CW;
  // Working width of the square root cells (sum of three squares fits)
  localparam int LW = 2 * CW + 3;
  // Vector length width
  localparam int LENW = CW + 1;
  // Quotient bits and divider remainder width
  localparam int QW = CW;
  localparam int DRW = LENW + QW;
  // Chain lengths
  localparam int SQ_STEPS = LENW;
  localparam int DIV_STEPS = QW;

  // Beat moving through the square root chain
  typedef struct packed {
    logic                   vld;
    logic [LW-1:0]          rem;
    logic [LW-1:0]          root;
    logic [2:0]             sgn;
    logic [2:0][MW-1:0]     mag;
    logic                   neg;
    logic                   deg;
  } sq_t;

  // Beat moving through the divider chain, three lanes side by side
  typedef struct packed {
    logic                   vld;
    logic [2:0][DRW-1:0]    rem;
    logic [2:0][QW-1:0]     quo;
    logic [LENW-1:0]        len;
    logic [2:0]             sgn;
    logic                   neg;
    logic                   deg;
  } div_t;

endpackage

// ===== sv/tfo_sqrt_cell.sv =====
// One digit cell of the integer square root chain.
`timescale 1ns / 1ps

module tfo_sqrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [4:0]          idx,
  input  tfo_pkg::sq_t        d_in,
  output tfo_pkg::sq_t        d_out
);

  tfo_pkg::sq_t           q_r;
  tfo_pkg::sq_t           q_nxt;
  logic [tfo_pkg::LW-1:0] bit_w;
  logic [tfo_pkg::LW-1:0] trial;

  // bit = 4^idx; try subtracting root + bit
  always_comb begin
    bit_w = tfo_pkg::LW'(1) << {idx, 1'b0};
    trial = d_in.root + bit_w;
    q_nxt = d_in;
    if (d_in.rem >= trial) begin
      q_nxt.rem  = d_in.rem - trial;
      q_nxt.root = (d_in.root >> 1) + bit_w;
    end else begin
      q_nxt.root = d_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

// ===== sv/tfo_div_cell.sv =====
// One quotient-bit cell of the three-lane restoring divider chain.
`timescale 1ns / 1ps

module tfo_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [3:0]          sh,
  input  tfo_pkg::div_t       d_in,
  output tfo_pkg::div_t       d_out
);

  tfo_pkg::div_t           q_r;
  tfo_pkg::div_t           q_nxt;
  logic [tfo_pkg::DRW-1:0] dv;

  // compare each lane against len << sh, subtract on fit
  always_comb begin
    dv    = tfo_pkg::DRW'(d_in.len) << sh;
    q_nxt = d_in;
    for (int i = 0; i < 3; i++) begin
      if (d_in.rem[i] >= dv) begin
        q_nxt.rem[i] = d_in.rem[i] - dv;
        q_nxt.quo[i] = d_in.quo[i] | (tfo_pkg::QW'(1) << sh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

// ===== sv/tangent_frame_orthonormalize.sv =====
// Top level: Gram-Schmidt tangent orthonormalizer with handedness bit.
//
// Input channel: one vertex per beat (tangent, bitangent, normal, Q1.14),
// taken when in_valid is high and in_stall is low.
// Output channel: unit tangent (Q1.14, saturated), handedness and
// degenerate flags, offered on out_valid and held while out_stall is high.
// Throughput: one vertex per cycle while in_stall is low. Depth: 40 register
// stages: six arithmetic stages (products, dot and cross products,
// projection and determinant terms, remainder, squares, length sum), a
// chain of 17 square root cells (one result bit each), a chain of 16
// divider cells (one quotient bit each, three lanes), and the output register.
// The whole pipeline advances together; while a result sits in the output
// register under stall, in_stall is raised and every stage holds.
// Reset (synchronous, rst_n low) clears all valid bits; no result is lost
// or repeated across a stall. A zero-length remainder yields a zero vector
// with the degenerate flag set.
`timescale 1ns / 1ps

module tangent_frame_orthonormalize (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [15:0]       in_tan_x,
  input  logic signed [15:0]       in_tan_y,
  input  logic signed [15:0]       in_tan_z,
  input  logic signed [15:0]       in_bitan_x,
  input  logic signed [15:0]       in_bitan_y,
  input  logic signed [15:0]       in_bitan_z,
  input  logic signed [15:0]       in_norm_x,
  input  logic signed [15:0]       in_norm_y,
  input  logic signed [15:0]       in_norm_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       out_x,
  output logic signed [15:0]       out_y,
  output logic signed [15:0]       out_z,
  output logic                     out_handed_negative,
  output logic                     out_degenerate
);

  localparam logic signed [35:0] HALF = 36'sd8192;
  localparam logic signed [35:0] LIM  = 36'sd65535;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // stage 1: all component products
  logic                      v1_r;
  logic signed [2:0][31:0]   p1_r;
  logic signed [5:0][31:0]   x1_r;
  logic signed [2:0][15:0]   t1_r, b1_r, n1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r[0] <= in_norm_x * in_tan_x;
      p1_r[1] <= in_norm_y * in_tan_y;
      p1_r[2] <= in_norm_z * in_tan_z;
      x1_r[0] <= in_norm_y * in_tan_z;
      x1_r[1] <= in_norm_z * in_tan_y;
      x1_r[2] <= in_norm_z * in_tan_x;
      x1_r[3] <= in_norm_x * in_tan_z;
      x1_r[4] <= in_norm_x * in_tan_y;
      x1_r[5] <= in_norm_y * in_tan_x;
      t1_r    <= {in_tan_z, in_tan_y, in_tan_x};
      b1_r    <= {in_bitan_z, in_bitan_y, in_bitan_x};
      n1_r    <= {in_norm_z, in_norm_y, in_norm_x};
    end
  end

  // stage 2: rounded, saturated dot product and cross product
  logic                      v2_r;
  logic signed [17:0]        d2_r;
  logic signed [2:0][32:0]   c2_r;
  logic signed [2:0][15:0]   t2_r, b2_r, n2_r;
  logic signed [35:0]        dsum;
  logic signed [35:0]        dq;
  logic signed [17:0]        d_nxt;

  // packed elements read back unsigned, so each one is cast to signed
  always_comb begin
    dsum = 36'(signed'(p1_r[0])) + 36'(signed'(p1_r[1])) + 36'(signed'(p1_r[2])) + HALF;
    dq   = dsum >>> tfo_pkg::FW;
    if (dq > LIM) begin
      d_nxt = 18'(LIM);
    end else if (dq < -LIM) begin
      d_nxt = 18'(-LIM);
    end else begin
      d_nxt = dq[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r    <= d_nxt;
      c2_r[0] <= 33'(signed'(x1_r[0])) - 33'(signed'(x1_r[1]));
      c2_r[1] <= 33'(signed'(x1_r[2])) - 33'(signed'(x1_r[3]));
      c2_r[2] <= 33'(signed'(x1_r[4])) - 33'(signed'(x1_r[5]));
      t2_r    <= t1_r;
      b2_r    <= b1_r;
      n2_r    <= n1_r;
    end
  end

  // stage 3: determinant terms and projection products
  logic                      v3_r;
  logic signed [2:0][48:0]   e3_r;
  logic signed [2:0][33:0]   pr3_r;
  logic signed [2:0][15:0]   t3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e3_r[i]  <= signed'(c2_r[i]) * signed'(b2_r[i]);
        pr3_r[i] <= signed'(n2_r[i]) * d2_r;
      end
      t3_r <= t2_r;
    end
  end

  // stage 4: handedness sign and saturated remainder
  logic                      v4_r;
  logic                      neg4_r;
  logic [2:0]                sgn4_r;
  logic [2:0][15:0]          mag4_r;
  logic signed [50:0]        det;
  logic signed [35:0]        pj   [3];
  logic signed [35:0]        diff [3];
  logic signed [35:0]        rs   [3];
  logic [35:0]               rabs [3];

  always_comb begin
    det = 51'(signed'(e3_r[0])) + 51'(signed'(e3_r[1])) + 51'(signed'(e3_r[2]));
    for (int i = 0; i < 3; i++) begin
      pj[i]   = (36'(signed'(pr3_r[i])) + HALF) >>> tfo_pkg::FW;
      diff[i] = 36'(signed'(t3_r[i])) - pj[i];
      if (diff[i] > LIM) begin
        rs[i] = LIM;
      end else if (diff[i] < -LIM) begin
        rs[i] = -LIM;
      end else begin
        rs[i] = diff[i];
      end
      rabs[i] = rs[i][35] ? 36'(-rs[i]) : 36'(rs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg4_r <= det[50];
      for (int i = 0; i < 3; i++) begin
        sgn4_r[i] <= rs[i][35];
        mag4_r[i] <= rabs[i][15:0];
      end
    end
  end

  // stage 5: squares
  logic                      v5_r;
  logic                      neg5_r;
  logic [2:0]                sgn5_r;
  logic [2:0][15:0]          mag5_r;
  logic [2:0][31:0]          sq5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq5_r[i] <= mag4_r[i] * mag4_r[i];
      end
      neg5_r <= neg4_r;
      sgn5_r <= sgn4_r;
      mag5_r <= mag4_r;
    end
  end

  // stage 6: squared length, start of the root chain
  tfo_pkg::sq_t              sq_chain [tfo_pkg::SQ_STEPS+1];
  tfo_pkg::sq_t              s6_r;
  logic [tfo_pkg::LW-1:0]    lsum;

  assign lsum = tfo_pkg::LW'(sq5_r[0]) + tfo_pkg::LW'(sq5_r[1]) + tfo_pkg::LW'(sq5_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_r.vld <= 1'b0;
    end else if (en) begin
      s6_r.vld  <= v5_r;
      s6_r.rem  <= lsum;
      s6_r.root <= '0;
      s6_r.sgn  <= sgn5_r;
      s6_r.mag  <= mag5_r;
      s6_r.neg  <= neg5_r;
      s6_r.deg  <= (lsum == '0);
    end
  end

  assign sq_chain[0] = s6_r;

  // square root chain, one result bit per cell
  for (genvar k = 0; k < tfo_pkg::SQ_STEPS; k++) begin : g_sqrt
    tfo_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .idx   (5'(tfo_pkg::SQ_STEPS - 1 - k)),
      .d_in  (sq_chain[k]),
      .d_out (sq_chain[k+1])
    );
  end

  // divider seed: (|r| << F) + len/2 in each lane
  tfo_pkg::div_t             div_chain [tfo_pkg::DIV_STEPS+1];
  tfo_pkg::div_t             div_seed;
  tfo_pkg::sq_t              sq_end;
  logic [tfo_pkg::LENW-1:0]  len;

  assign sq_end = sq_chain[tfo_pkg::SQ_STEPS];
  assign len    = sq_end.root[tfo_pkg::LENW-1:0];

  always_comb begin
    div_seed.vld = sq_end.vld;
    div_seed.len = len;
    div_seed.sgn = sq_end.sgn;
    div_seed.neg = sq_end.neg;
    div_seed.deg = sq_end.deg;
    div_seed.quo = '0;
    for (int i = 0; i < 3; i++) begin
      div_seed.rem[i] = (tfo_pkg::DRW'(sq_end.mag[i]) << tfo_pkg::FW)
                      + tfo_pkg::DRW'(len >> 1);
    end
  end

  assign div_chain[0] = div_seed;

  // divider chain, one quotient bit per cell
  for (genvar k = 0; k < tfo_pkg::DIV_STEPS; k++) begin : g_div
    tfo_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .sh    (4'(tfo_pkg::DIV_STEPS - 1 - k)),
      .d_in  (div_chain[k]),
      .d_out (div_chain[k+1])
    );
  end

  // output register: sign, saturation, degenerate zeroing
  tfo_pkg::div_t             dv_end;
  logic signed [2:0][15:0]   o_nxt;
  logic                      ov_r;
  logic signed [2:0][15:0]   o_r;
  logic                      oneg_r, odeg_r;

  assign dv_end = div_chain[tfo_pkg::DIV_STEPS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_end.deg) begin
        o_nxt[i] = '0;
      end else if (dv_end.sgn[i]) begin
        o_nxt[i] = (dv_end.quo[i] >= 16'd32768) ? 16'h8000 : 16'(-dv_end.quo[i]);
      end else begin
        o_nxt[i] = (dv_end.quo[i] >= 16'd32767) ? 16'h7FFF : dv_end.quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= dv_end.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r    <= o_nxt;
      oneg_r <= dv_end.neg;
      odeg_r <= dv_end.deg;
    end
  end

  assign out_valid           = ov_r;
  assign out_x               = o_r[0];
  assign out_y               = o_r[1];
  assign out_z               = o_r[2];
  assign out_handed_negative = oneg_r;
  assign out_degenerate      = odeg_r;

endmodule

// ===== test/tangent_frame_orthonormalize_test.sv =====
// Testbench for the tangent frame orthonormalizer: directed and random vertices, scoreboard check.
`timescale 1ns / 1ps

module tangent_frame_orthonormalize_test;

  localparam int NUM_RANDOM = 1800;
  localparam longint REM_LIM = 65535;
  localparam longint HALF = 8192;

  typedef struct {
    shortint t[3];
    shortint b[3];
    shortint n[3];
  } vertex_t;

  typedef struct {
    shortint v[3];
    bit      neg;
    bit      deg;
  } frame_t;

  // Tracks accepted vertices and predicts the frame each one should produce
  class frame_scoreboard;
    frame_t expected_frames[$];

    static function longint clamp(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    static function longint root_floor(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Gram-Schmidt step, unit scaling and handedness sign
    static function frame_t orthonormalize(vertex_t vx);
      longint dot, d, proj, sq, len, m, det;
      longint r[3];
      longint n[3];
      longint t[3];
      longint b[3];
      frame_t f;
      for (int i = 0; i < 3; i++) begin
        n[i] = vx.n[i];
        t[i] = vx.t[i];
        b[i] = vx.b[i];
      end
      dot = n[0] * t[0] + n[1] * t[1] + n[2] * t[2];
      d = clamp((dot + HALF) >>> tfo_pkg::FW, -REM_LIM, REM_LIM);
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        proj = (n[i] * d + HALF) >>> tfo_pkg::FW;
        r[i] = clamp(t[i] - proj, -REM_LIM, REM_LIM);
        sq += r[i] * r[i];
      end
      det = (n[1] * t[2] - n[2] * t[1]) * b[0]
          + (n[2] * t[0] - n[0] * t[2]) * b[1]
          + (n[0] * t[1] - n[1] * t[0]) * b[2];
      f.neg = det < 0;
      f.deg = sq == 0;
      if (sq == 0) begin
        for (int i = 0; i < 3; i++) f.v[i] = 0;
      end else begin
        len = root_floor(sq);
        for (int i = 0; i < 3; i++) begin
          m = (((r[i] < 0 ? -r[i] : r[i]) << tfo_pkg::FW) + (len >> 1)) / len;
          if (m > 32768) m = 32768;
          f.v[i] = shortint'(clamp(r[i] < 0 ? -m : m, -32768, 32767));
        end
      end
      return f;
    endfunction

    function void note_vertex(vertex_t vx);
      expected_frames.insert(expected_frames.size(), orthonormalize(vx));
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    // Returns a description of the differences, empty when the beat matches
    function string check_frame(frame_t got);
      frame_t e;
      string diff;
      diff = "";
      if (expected_frames.size() == 0) return "result beat with nothing expected";
      e = expected_frames.pop_front();
      for (int i = 0; i < 3; i++)
        if (got.v[i] !== e.v[i])
          diff = {diff, $sformatf(" comp%0d got %0d exp %0d", i, got.v[i], e.v[i])};
      if (got.neg !== e.neg)
        diff = {diff, $sformatf(" handed_negative got %0b exp %0b", got.neg, e.neg)};
      if (got.deg !== e.deg)
        diff = {diff, $sformatf(" degenerate got %0b exp %0b", got.deg, e.deg)};
      return diff;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] in_tan_x = 0, in_tan_y = 0, in_tan_z = 0;
  logic signed [15:0] in_bitan_x = 0, in_bitan_y = 0, in_bitan_z = 0;
  logic signed [15:0] in_norm_x = 0, in_norm_y = 0, in_norm_z = 0;
  logic out_valid;
  logic out_stall = 1;
  logic signed [15:0] out_x, out_y, out_z;
  logic out_handed_negative, out_degenerate;

  frame_scoreboard sb = new();
  int errors = 0;
  int accepted = 0;
  bit sending_done = 0;
  bit hold_done = 0;
  vertex_t directed[$];

  tangent_frame_orthonormalize uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_tan_x(in_tan_x), .in_tan_y(in_tan_y), .in_tan_z(in_tan_z),
    .in_bitan_x(in_bitan_x), .in_bitan_y(in_bitan_y), .in_bitan_z(in_bitan_z),
    .in_norm_x(in_norm_x), .in_norm_y(in_norm_y), .in_norm_z(in_norm_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_handed_negative(out_handed_negative), .out_degenerate(out_degenerate)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  task report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic vertex_t mk(int t0, int t1, int t2, int b0, int b1, int b2,
                                 int n0, int n1, int n2);
    vertex_t v;
    v.t = '{shortint'(t0), shortint'(t1), shortint'(t2)};
    v.b = '{shortint'(b0), shortint'(b1), shortint'(b2)};
    v.n = '{shortint'(n0), shortint'(n1), shortint'(n2)};
    return v;
  endfunction

  function automatic shortint rnd16();
    return shortint'($urandom);
  endfunction

  // Random vertex: mostly plausible frames, some fully random noise
  function automatic vertex_t random_vertex();
    vertex_t v;
    int axis, sgn;
    for (int i = 0; i < 3; i++) begin
      v.t[i] = rnd16();
      v.b[i] = rnd16();
      v.n[i] = rnd16();
    end
    axis = $urandom_range(0, 2);
    sgn = $urandom_range(0, 1) ? 16384 : -16384;
    case ($urandom_range(0, 4))
      0: ;
      1, 2: begin
        // near axis-aligned unit normal, moderate tangent
        for (int i = 0; i < 3; i++) begin
          v.n[i] = shortint'((i == axis) ? sgn : int'($urandom_range(0, 3)) - 1);
          v.t[i] = shortint'(int'($urandom_range(0, 32768)) - 16384);
        end
      end
      3: begin
        // tangent along the normal: zero remainder
        for (int i = 0; i < 3; i++) begin
          v.n[i] = shortint'((i == axis) ? sgn : 0);
          v.t[i] = (i == axis) ? rnd16() : shortint'(0);
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) v.t[i] = shortint'(int'($urandom_range(0, 8)) - 4);
      end
    endcase
    return v;
  endfunction

  // Sender: holds a beat while stalled, idles by phase
  task drive_vertices();
    vertex_t cur;
    int total, sent_idx, idle_pct;
    total = directed.size() + NUM_RANDOM;
    sent_idx = 0;
    while (accepted < total) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        sb.note_vertex(cur);
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        idle_pct = accepted < total / 3 ? 24 : (accepted < 2 * total / 3 ? 81 : 0);
        if (sent_idx < total && $urandom_range(0, 99) >= idle_pct) begin
          cur = sent_idx < directed.size() ? directed[sent_idx] : random_vertex();
          sent_idx++;
          in_valid <= 1;
          in_tan_x <= cur.t[0];
          in_tan_y <= cur.t[1];
          in_tan_z <= cur.t[2];
          in_bitan_x <= cur.b[0];
          in_bitan_y <= cur.b[1];
          in_bitan_z <= cur.b[2];
          in_norm_x <= cur.n[0];
          in_norm_y <= cur.n[1];
          in_norm_z <= cur.n[2];
        end else begin
          in_valid <= 0;
        end
      end
    end
    sending_done = 1;
  endtask

  // Receiver: checks each beat, stalls by phase, one long hold-off
  task take_frames();
    frame_t got;
    string diff;
    int total, stall_pct, hold;
    total = directed.size() + NUM_RANDOM;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.v = '{out_x, out_y, out_z};
        got.neg = out_handed_negative;
        got.deg = out_degenerate;
        diff = sb.check_frame(got);
        if (diff != "") report(diff);
      end
      if (!hold_done && accepted > 2 * total / 3 + 50) begin
        hold_done = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1;
      end else begin
        stall_pct = accepted < total / 3 ? 81 : (accepted < 2 * total / 3 ? 24 : 0);
        out_stall <= $urandom_range(0, 99) < stall_pct;
      end
    end
  endtask

  initial begin
    directed = '{
      mk(0, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
      mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
      mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384),
      mk(16384, 0, 0, 0, -16384, 0, 0, 0, 16384),
      mk(16384, 0, 0, 0, 0, 0, 0, 0, 16384),
      mk(0, 0, -12345, 100, 200, 300, 0, 0, 16384),
      mk(-32768, -32768, -32768, 1, -1, 1, 32767, 32767, 32767),
      mk(32767, -32768, 1, -32768, 32767, 0, 0, 0, 0),
      mk(1, 0, 0, 0, 1, 0, 0, 0, 0),
      mk(1, 1, 0, 0, 0, 1, 0, 0, 0),
      mk(0, 0, -1, 1, 1, 1, 0, 0, 0),
      mk(32767, 32767, 32767, -1, 0, 1, -32768, -32768, -32768),
      mk(11585, 0, 11585, 0, 16384, 0, -11585, 0, 11585),
      mk(12000, -9000, 3000, -5000, 7000, 9000, 9459, 9459, 9459),
      mk(-1, -1, -1, 32767, -32768, 32767, 16384, -16384, 16384)
    };
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    fork
      drive_vertices();
      take_frames();
    join_none
    while (!sending_done || sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== tangent_frame_orthonormalize.f =====
sv/tfo_pkg.sv
sv/tfo_sqrt_cell.sv
sv/tfo_div_cell.sv
sv/tangent_frame_orthonormalize.sv
test/tangent_frame_orthonormalize_test.sv
